// ----- rtl/core/cppo_pkg.sv -----
// Shared types and constants for the cylinder pair overlap and push-out pipeline.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cppo_pkg;

    localparam int COORD_W    = 32;   // signed Q16.16 coordinate
    localparam int DIM_W      = 31;   // unsigned Q15.16 radius or height
    localparam int MAG_W      = 32;   // magnitude of a coordinate difference
    localparam int SQ_W       = 64;   // squares and products of magnitudes
    localparam int N2_W       = 128;  // square of a push numerator
    localparam int QUO_W      = 66;   // quotient of 4*n^2 / len_sq
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_W     = 33;   // floor root of the quotient
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQ_REM_W   = 34;   // partial remainder of the root stages
    localparam int FRONT_LAT  = 6;
    localparam int MID_LAT    = DIV_STEPS + SQRT_STEPS;
    localparam int TOTAL_LAT  = FRONT_LAT + MID_LAT + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic        [DIM_W-1:0]   a_radius;
        logic        [DIM_W-1:0]   a_height;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic        [DIM_W-1:0]   b_radius;
        logic        [DIM_W-1:0]   b_height;
    } in_item_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
    } coord_t;

    typedef struct packed {
        logic   hit;
        logic   zero;
        logic   neg_x;
        logic   neg_z;
        coord_t pos;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [SQ_W-1:0]   len_sq;
        logic [N2_W-1:0]   n2_x;
        logic [N2_W-1:0]   n2_z;
    } front_t;

endpackage

`default_nettype wire

// ----- rtl/core/cylinder_pair_overlap_pushout_top.sv -----
// Top level of the cylinder pair overlap and push-out pipeline.
// Depends on cppo_pkg, cppo_front, cppo_div and cppo_isqrt.
//
// Usage:
//   One item on in_item (valid/ready) describes two upright cylinders A and B.
//   One item on out_item follows for every input item, in order: hit flag and
//   B's position, pushed out in XZ to the radius sum from A on a hit.
//   From acceptance to out_valid an item passes 6 front stages, a
//   66-stage divider (one quotient bit per stage), a 33-stage square root
//   (one root bit per stage), a rounding stage and the output register.
//   Throughput is one item per cycle while the receiver takes results.
//   The whole pipeline advances together; when out_valid is high and
//   out_ready is low, every stage holds and in_ready drops, so nothing is
//   lost or repeated. Bubbles in the pipeline stay where they are.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
`timescale 1ns / 1ps
`default_nettype none

module cylinder_pair_overlap_pushout_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cppo_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cppo_pkg::out_item_t out_item
);
    import cppo_pkg::*;

    logic                 adv;
    logic [TOTAL_LAT-1:0] vld_reg;
    front_t               front;
    logic [QUO_W-1:0]     quo_x, quo_z;
    logic [ROOT_W-1:0]    root_x, root_z;
    side_t                side_reg [MID_LAT];
    logic [ROOT_W:0]      rnd_x, rnd_z;
    logic [ROOT_W-1:0]    off_x_reg, off_z_reg;
    side_t                side_off_reg;
    out_item_t            out_next;
    out_item_t            out_reg;

    function automatic logic [COORD_W-1:0] push_coord(
        input logic [COORD_W-1:0] base,
        input logic               neg,
        input logic [ROOT_W-1:0]  off
    );
        logic [33:0] sum;
        begin
            if (neg)
                sum = {{2{base[31]}}, base} - {1'b0, off};
            else
                sum = {{2{base[31]}}, base} + {1'b0, off};
            // saturate to the signed 32-bit range
            if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
                push_coord = sum[31:0];
            else if (sum[33])
                push_coord = {1'b1, 31'd0};
            else
                push_coord = {1'b0, {31{1'b1}}};
        end
    endfunction

    assign adv      = !vld_reg[TOTAL_LAT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
    end

    cppo_front u_front (
        .clk     (clk),
        .adv     (adv),
        .in_item (in_item),
        .front   (front)
    );

    cppo_div u_div_x (
        .clk (clk),
        .adv (adv),
        .n2  (front.n2_x),
        .dvs (front.len_sq),
        .quo (quo_x)
    );

    cppo_div u_div_z (
        .clk (clk),
        .adv (adv),
        .n2  (front.n2_z),
        .dvs (front.len_sq),
        .quo (quo_z)
    );

    cppo_isqrt u_sqrt_x (
        .clk  (clk),
        .adv  (adv),
        .rad  (quo_x),
        .root (root_x)
    );

    cppo_isqrt u_sqrt_z (
        .clk  (clk),
        .adv  (adv),
        .rad  (quo_z),
        .root (root_z)
    );

    // hold the sideband alongside the divider and root stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= front.side;
            for (int j = 1; j < MID_LAT; j++)
                side_reg[j] <= side_reg[j-1];
        end
    end

    // floor(2q) -> round(q), ties away from zero
    assign rnd_x = {1'b0, root_x} + {{ROOT_W{1'b0}}, 1'b1};
    assign rnd_z = {1'b0, root_z} + {{ROOT_W{1'b0}}, 1'b1};

    always_comb
    begin
        out_next.hit   = side_off_reg.hit;
        out_next.out_y = side_off_reg.pos.b_y;
        if (!side_off_reg.hit)
        begin
            out_next.out_x = side_off_reg.pos.b_x;
            out_next.out_z = side_off_reg.pos.b_z;
        end
        else if (side_off_reg.zero)
        begin
            out_next.out_x = side_off_reg.pos.a_x;
            out_next.out_z = side_off_reg.pos.a_z;
        end
        else
        begin
            out_next.out_x = push_coord(side_off_reg.pos.a_x, side_off_reg.neg_x, off_x_reg);
            out_next.out_z = push_coord(side_off_reg.pos.a_z, side_off_reg.neg_z, off_z_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_x_reg    <= rnd_x[ROOT_W:1];
            off_z_reg    <= rnd_z[ROOT_W:1];
            side_off_reg <= side_reg[MID_LAT-1];
            out_reg      <= out_next;
        end
    end

    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cppo_front.sv -----
// Front stages: vertical test, XZ distance, hit decision and squared push numerators.
// Six register stages; depends on cppo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cppo_front (
    input  logic               clk,
    input  logic               adv,
    input  cppo_pkg::in_item_t in_item,
    output cppo_pkg::front_t   front
);
    import cppo_pkg::*;

    // stage 1
    logic signed [33:0]        ay_ext, by_ext, a_top, b_top;
    logic                      vert_next;
    logic signed [32:0]        dx_next, dz_next;
    logic [MAG_W-1:0]          range_next;
    coord_t                    pos_next;
    logic                      vert1_reg;
    logic signed [32:0]        dx1_reg, dz1_reg;
    logic [MAG_W-1:0]          range1_reg;
    coord_t                    pos1_reg;

    // stage 2
    logic [32:0]               abs_x, abs_z;
    logic                      vert2_reg, neg_x2_reg, neg_z2_reg;
    logic [MAG_W-1:0]          mx2_reg, mz2_reg, range2_reg;
    coord_t                    pos2_reg;

    // stage 3
    logic [SQ_W-1:0]           sx_next, sz_next, rsq_next, nx_next, nz_next;
    logic [SQ_W-1:0]           sx3_reg, sz3_reg, rsq3_reg, nx3_reg, nz3_reg;
    logic                      vert3_reg, neg_x3_reg, neg_z3_reg;
    coord_t                    pos3_reg;

    // stage 4
    logic [SQ_W:0]             len_next;
    side_t                     side_next;
    logic [SQ_W-1:0]           hh_x_next, hl_x_next, ll_x_next;
    logic [SQ_W-1:0]           hh_z_next, hl_z_next, ll_z_next;
    side_t                     side4_reg;
    logic [SQ_W-1:0]           len4_reg;
    logic [SQ_W-1:0]           hh_x4_reg, hl_x4_reg, ll_x4_reg;
    logic [SQ_W-1:0]           hh_z4_reg, hl_z4_reg, ll_z4_reg;

    // stage 5
    logic [96:0]               t_x_next, t_z_next;
    logic [96:0]               t_x5_reg, t_z5_reg;
    logic [SQ_W-1:0]           ll_x5_reg, ll_z5_reg, len5_reg;
    side_t                     side5_reg;

    // stage 6
    logic [96:0]               up_x, up_z;
    front_t                    front_next;
    front_t                    front_reg;

    assign ay_ext     = {{2{in_item.a_y[31]}}, in_item.a_y};
    assign by_ext     = {{2{in_item.b_y[31]}}, in_item.b_y};
    assign a_top      = ay_ext + {3'b000, in_item.a_height};
    assign b_top      = by_ext + {3'b000, in_item.b_height};
    // touching spans still overlap
    assign vert_next  = !(ay_ext > b_top) && !(a_top < by_ext);
    assign dx_next    = {in_item.b_x[31], in_item.b_x} - {in_item.a_x[31], in_item.a_x};
    assign dz_next    = {in_item.b_z[31], in_item.b_z} - {in_item.a_z[31], in_item.a_z};
    assign range_next = {1'b0, in_item.a_radius} + {1'b0, in_item.b_radius};
    assign pos_next   = {in_item.a_x, in_item.a_z, in_item.b_x, in_item.b_y, in_item.b_z};

    assign abs_x = dx1_reg[32] ? (33'd0 - dx1_reg) : dx1_reg;
    assign abs_z = dz1_reg[32] ? (33'd0 - dz1_reg) : dz1_reg;

    assign sx_next  = mx2_reg * mx2_reg;
    assign sz_next  = mz2_reg * mz2_reg;
    assign rsq_next = range2_reg * range2_reg;
    assign nx_next  = mx2_reg * range2_reg;
    assign nz_next  = mz2_reg * range2_reg;

    assign len_next  = {1'b0, sx3_reg} + {1'b0, sz3_reg};
    assign hh_x_next = nx3_reg[63:32] * nx3_reg[63:32];
    assign hl_x_next = nx3_reg[63:32] * nx3_reg[31:0];
    assign ll_x_next = nx3_reg[31:0] * nx3_reg[31:0];
    assign hh_z_next = nz3_reg[63:32] * nz3_reg[63:32];
    assign hl_z_next = nz3_reg[63:32] * nz3_reg[31:0];
    assign ll_z_next = nz3_reg[31:0] * nz3_reg[31:0];

    always_comb
    begin
        side_next.hit   = vert3_reg && (len_next < {1'b0, rsq3_reg});
        side_next.zero  = (len_next == '0);
        side_next.neg_x = neg_x3_reg;
        side_next.neg_z = neg_z3_reg;
        side_next.pos   = pos3_reg;
    end

    // n^2 = hh*2^64 + 2*hl*2^32 + ll; first fold the upper terms
    assign t_x_next = {1'b0, hh_x4_reg, 32'd0} + {32'd0, hl_x4_reg, 1'b0};
    assign t_z_next = {1'b0, hh_z4_reg, 32'd0} + {32'd0, hl_z4_reg, 1'b0};

    assign up_x = t_x5_reg + {65'd0, ll_x5_reg[63:32]};
    assign up_z = t_z5_reg + {65'd0, ll_z5_reg[63:32]};

    always_comb
    begin
        front_next.side   = side5_reg;
        front_next.len_sq = len5_reg;
        front_next.n2_x   = {up_x[95:0], ll_x5_reg[31:0]};
        front_next.n2_z   = {up_z[95:0], ll_z5_reg[31:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vert1_reg  <= vert_next;
            dx1_reg    <= dx_next;
            dz1_reg    <= dz_next;
            range1_reg <= range_next;
            pos1_reg   <= pos_next;

            vert2_reg  <= vert1_reg;
            neg_x2_reg <= dx1_reg[32];
            neg_z2_reg <= dz1_reg[32];
            mx2_reg    <= abs_x[31:0];
            mz2_reg    <= abs_z[31:0];
            range2_reg <= range1_reg;
            pos2_reg   <= pos1_reg;

            sx3_reg    <= sx_next;
            sz3_reg    <= sz_next;
            rsq3_reg   <= rsq_next;
            nx3_reg    <= nx_next;
            nz3_reg    <= nz_next;
            vert3_reg  <= vert2_reg;
            neg_x3_reg <= neg_x2_reg;
            neg_z3_reg <= neg_z2_reg;
            pos3_reg   <= pos2_reg;

            side4_reg  <= side_next;
            len4_reg   <= len_next[63:0];
            hh_x4_reg  <= hh_x_next;
            hl_x4_reg  <= hl_x_next;
            ll_x4_reg  <= ll_x_next;
            hh_z4_reg  <= hh_z_next;
            hl_z4_reg  <= hl_z_next;
            ll_z4_reg  <= ll_z_next;

            t_x5_reg   <= t_x_next;
            t_z5_reg   <= t_z_next;
            ll_x5_reg  <= ll_x4_reg;
            ll_z5_reg  <= ll_z4_reg;
            len5_reg   <= len4_reg;
            side5_reg  <= side4_reg;

            front_reg  <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cppo_div.sv -----
// Pipelined restoring divider: floor(4*n2 / dvs), one quotient bit per stage.
// Depends on cppo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cppo_div (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [cppo_pkg::N2_W-1:0]   n2,
    input  logic [cppo_pkg::SQ_W-1:0]   dvs,
    output logic [cppo_pkg::QUO_W-1:0]  quo
);
    import cppo_pkg::*;

    logic [SQ_W-1:0]  rem_reg [DIV_STEPS];
    logic [SQ_W-1:0]  low_reg [DIV_STEPS];
    logic [SQ_W-1:0]  dvs_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic [SQ_W-1:0]  rem_next [DIV_STEPS];
    logic [QUO_W-1:0] quo_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [SQ_W-1:0]  rem_in, low_in, dvs_in;
        logic [QUO_W-1:0] quo_in;
        logic             nbit;
        logic [SQ_W:0]    trial, diff;
        logic             take;

        if (k == 0)
        begin : g_first
            // the upper half of n^2 is already below the divisor on a hit
            assign rem_in = n2[N2_W-1:SQ_W];
            assign low_in = n2[SQ_W-1:0];
            assign dvs_in = dvs;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // the factor four appends two zero bits
        if (k < SQ_W)
        begin : g_bit
            assign nbit = low_in[SQ_W-1-k];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_in, nbit};
        assign diff  = trial - {1'b0, dvs_in};
        assign take  = (trial >= {1'b0, dvs_in});
        assign rem_next[k] = take ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
        assign quo_next[k] = {quo_in[QUO_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_in;
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/cppo_isqrt.sv -----
// Pipelined integer square root, one root bit per stage (bit-pair recurrence).
// Depends on cppo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cppo_isqrt (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [cppo_pkg::QUO_W-1:0]  rad,
    output logic [cppo_pkg::ROOT_W-1:0] root
);
    import cppo_pkg::*;

    logic [SQ_REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0]   root_reg [SQRT_STEPS];
    logic [QUO_W-1:0]    rad_reg  [SQRT_STEPS];
    logic [SQ_REM_W-1:0] rem_next  [SQRT_STEPS];
    logic [ROOT_W-1:0]   root_next [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam int PAIR = SQRT_STEPS - 1 - k;
        logic [SQ_REM_W-1:0] rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [QUO_W-1:0]    rad_in;
        logic [SQ_REM_W+1:0] cur, trial, diff;
        logic                take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[2*PAIR+1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = cur - trial;
        assign take  = (cur >= trial);
        assign rem_next[k]  = take ? diff[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
        assign root_next[k] = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_in;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/cppo_checker.sv -----
// Port-level checks for the cylinder pair overlap top level, bound to every instance.
// Depends on cppo_pkg and cylinder_pair_overlap_pushout_top.
`timescale 1ns / 1ps
`default_nettype none

module cppo_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input cppo_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_ready,
    input cppo_pkg::out_item_t out_item
);
    import cppo_pkg::*;

    // an offered item waits unchanged until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("waiting input item changed");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // the pipeline takes an item exactly when its last stage can move
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    // a stall that persists keeps the input closed
    a_stall_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !in_ready || out_ready)
        else $error("input opened during a held stall");

endmodule

bind cylinder_pair_overlap_pushout_top cppo_checker u_cppo_checker (.*);

`default_nettype wire

// ----- tb/tb_cylinder_pair_overlap_pushout_top.sv -----
// Testbench for cylinder_pair_overlap_pushout_top: directed and random cylinder pairs,
// each result checked against an in-bench bit-exact push-out predictor.
// Depends on cppo_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_cylinder_pair_overlap_pushout_top;
    import cppo_pkg::*;

    localparam int PIPE_LAT = 107;
    localparam int STALL_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    out_item_t expected_q[$];
    int        mismatch_count = 0;
    int        sent_count = 0;
    int        result_count = 0;
    int        hit_count = 0;
    int        idle_cycles = 0;
    bit        hold_off = 1'b0;
    int        hold_cycles = 0;

    always #2 clk = ~clk;

    cylinder_pair_overlap_pushout_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // floor square root, exact, of a value below 2^68
    function automatic logic [63:0] floor_root(input logic [131:0] w);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({68'd0, c} * {68'd0, c} <= w)
                r = c;
        end
        return r;
    endfunction

    // round(mag * range / sqrt(len_sq)) through floor(sqrt(4*n^2/len_sq))
    function automatic logic [63:0] pushout_offset(input logic [63:0] mag,
                                                   input logic [63:0] range,
                                                   input logic [63:0] len_sq);
        logic [131:0] n;
        logic [131:0] q;
        logic [63:0]  s;
        n = {68'd0, mag * range};
        q = ((n * n) << 2) / {68'd0, len_sq};
        s = floor_root(q);
        return (s + 64'd1) >> 1;
    endfunction

    function automatic logic signed [31:0] offset_sat(input logic signed [31:0] base,
                                                      input logic neg,
                                                      input logic [63:0] off);
        logic signed [65:0] v;
        v = neg ? $signed({{34{base[31]}}, base}) - $signed({2'b0, off})
                : $signed({{34{base[31]}}, base}) + $signed({2'b0, off});
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic out_item_t predict_pushout(input in_item_t p);
        out_item_t   r;
        logic signed [33:0] dx, dz, ytop_b, ytop_a;
        logic [63:0] mx, mz, sx, sz, range;
        logic [64:0] len_sq;
        r.hit = 1'b0;
        r.out_x = p.b_x;
        r.out_y = p.b_y;
        r.out_z = p.b_z;
        ytop_b = 34'(p.b_y) + $signed({3'b0, p.b_height});
        ytop_a = 34'(p.a_y) + $signed({3'b0, p.a_height});
        if (!(34'(p.a_y) > ytop_b) && !(ytop_a < 34'(p.b_y)))
        begin
            dx = 34'(p.b_x) - 34'(p.a_x);
            dz = 34'(p.b_z) - 34'(p.a_z);
            mx = dx < 0 ? 64'(-dx) : 64'(dx);
            mz = dz < 0 ? 64'(-dz) : 64'(dz);
            sx = mx * mx;
            sz = mz * mz;
            len_sq = {1'b0, sx} + {1'b0, sz};
            range = 64'(p.a_radius) + 64'(p.b_radius);
            if (!len_sq[64] && len_sq[63:0] < range * range)
            begin
                r.hit = 1'b1;
                if (len_sq == 0)
                begin
                    r.out_x = p.a_x;
                    r.out_z = p.a_z;
                end
                else
                begin
                    r.out_x = offset_sat(p.a_x, dx < 0,
                                         pushout_offset(mx, range, len_sq[63:0]));
                    r.out_z = offset_sat(p.a_z, dz < 0,
                                         pushout_offset(mz, range, len_sq[63:0]));
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %h expected %h", result_count, what, got,
                 want);
    endtask

    // valid stays up after acceptance until the next item or an idle gap replaces it
    task automatic send_pair(input in_item_t p);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= p;
        expected_q.push_back(predict_pushout(p));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_dim();
        case ($urandom_range(0, 4))
            0: return 31'h7fffffff;
            1: return '0;
            2: return 31'($urandom_range(0, 4000));
            default: return 31'($urandom);
        endcase
    endfunction

    // mostly near pairs so the hit path and push-out get exercised
    function automatic in_item_t rand_pair();
        in_item_t p;
        p.a_x = rand_coord();
        p.a_y = rand_coord();
        p.a_z = rand_coord();
        p.a_radius = rand_dim();
        p.a_height = rand_dim();
        p.b_radius = rand_dim();
        p.b_height = rand_dim();
        if ($urandom_range(0, 3) != 0)
        begin
            p.a_radius = 31'($urandom_range(0, 32'h0100_0000));
            p.b_radius = 31'($urandom_range(0, 32'h0100_0000));
            p.b_x = p.a_x + ($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
            p.b_z = p.a_z + ($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
            p.b_y = p.a_y + ($urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
            p.a_height = 31'($urandom_range(0, 32'h0100_0000));
            p.b_height = 31'($urandom_range(0, 32'h0100_0000));
        end
        else
        begin
            p.b_x = rand_coord();
            p.b_y = rand_coord();
            p.b_z = rand_coord();
        end
        return p;
    endfunction

    task automatic test_directed();
        in_item_t p;
        p = '0;
        p.a_radius = 31'h10000;
        p.b_radius = 31'h10000;
        send_pair(p);                       // coincident centers
        p.b_x = 32'h8000;
        send_pair(p);                       // push along +x
        p.b_x = -32'sh8000;
        p.b_z = 32'h4000;
        send_pair(p);                       // negative x
        p.a_radius = '0;
        p.b_radius = '0;
        send_pair(p);                       // zero radius sum
        p.a_radius = 31'h7fffffff;
        p.b_radius = 31'h7fffffff;
        p.a_height = 31'h7fffffff;
        p.b_height = 31'h7fffffff;
        p.a_x = 32'h7fffffff;
        p.b_x = 32'h7ffffffe;
        p.a_z = 32'h80000000;
        p.b_z = 32'h80000001;
        send_pair(p);                       // large push near both coordinate extremes
        p.a_x = 32'h80000000;
        p.b_x = 32'h7fffffff;
        p.a_z = 32'h80000000;
        p.b_z = 32'h7fffffff;
        send_pair(p);                       // huge distance
        p = '0;
        p.a_radius = 31'h10000;
        p.b_radius = 31'h10000;
        p.b_x = 32'h20000;
        send_pair(p);                       // exactly touching, no hit
        p.b_x = 32'h1000;
        p.b_y = 32'h10001;
        p.a_height = 31'h10000;
        send_pair(p);                       // just above A
        p.b_y = 32'h10000;
        send_pair(p);                       // spans touch
        p.b_y = -32'sh10001;
        p.b_height = 31'h10000;
        send_pair(p);                       // just below A
        p.a_y = 32'h7fffffff;
        p.b_y = 32'h80000000;
        p.b_height = 31'h7fffffff;
        send_pair(p);                       // extreme y
        p = '1;
        send_pair(p);                       // all ones
        drain_results();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++)
        begin
            in_valid <= 1'b1;
            in_item <= rand_pair();
            @(posedge clk);
            expected_q.push_back(predict_pushout(in_item));
            while (!in_ready)
                @(posedge clk);
            sent_count++;
        end
        drain_results();
    endtask

    // receiver: random stalls per result, plus one long hold-off on request
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_n = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0)
                wait_n = 0;
            if (wait_n != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", out_item.out_x, 32'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_item.hit !== want.hit)
                    report_mismatch("hit", 32'(out_item.hit), 32'(want.hit));
                if (out_item.out_x !== want.out_x)
                    report_mismatch("out_x", out_item.out_x, want.out_x);
                if (out_item.out_y !== want.out_y)
                    report_mismatch("out_y", out_item.out_y, want.out_y);
                if (out_item.out_z !== want.out_z)
                    report_mismatch("out_z", out_item.out_z, want.out_z);
                hit_count += want.hit;
            end
            result_count++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb_cylinder_pair_overlap_pushout_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(250);
        test_backpressure();
        test_random(300);
        drain_results();
        repeat (PIPE_LAT + 20) @(posedge clk);
        $display("covered %0d pairs, %0d results, %0d hits, incl. long output stall",
                 sent_count, result_count, hit_count);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("tb_cylinder_pair_overlap_pushout_top: done, clean");
        else
            $display("tb_cylinder_pair_overlap_pushout_top: done, errors");
        $finish;
    end
endmodule
